// ===== hdl/mbfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbfd_pkg
// shared types, codes and helpers of the manchester backward frame decoder
// ----------------------------------------------------------------------------
package mbfd_pkg;

  localparam int FrameWidth = 16;
  localparam int TimeWidth  = 16;
  localparam int OutWidth   = 16;
  localparam int AnswerBit  = 8;

  // input operations
  localparam logic [1:0] OP_RISE = 2'd0;
  localparam logic [1:0] OP_FALL = 2'd1;
  localparam logic [1:0] OP_END  = 2'd2;

  // result status
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_HIGH_BAD = 2'd1;
  localparam logic [1:0] ST_LOW_BAD  = 2'd2;
  localparam logic [1:0] ST_ILLEGAL  = 2'd3;

  // register indexes
  localparam logic [1:0] REG_SHORT_MIN = 2'd0;
  localparam logic [1:0] REG_SHORT_MAX = 2'd1;
  localparam logic [1:0] REG_LONG_MIN  = 2'd2;
  localparam logic [1:0] REG_LONG_MAX  = 2'd3;

  localparam logic [TimeWidth-1:0] SHORT_MIN_RST = TimeWidth'(333);
  localparam logic [TimeWidth-1:0] SHORT_MAX_RST = TimeWidth'(500);
  localparam logic [TimeWidth-1:0] LONG_MIN_RST  = TimeWidth'(667);
  localparam logic [TimeWidth-1:0] LONG_MAX_RST  = TimeWidth'(1000);

  // time classes
  localparam logic [1:0] CLS_SHORT = 2'd0;
  localparam logic [1:0] CLS_LONG  = 2'd1;
  localparam logic [1:0] CLS_BAD   = 2'd2;

  // decode table index {last half bit, low long, high long}
  localparam logic [2:0] DEC_ZERO      = 3'd0;
  localparam logic [2:0] DEC_ZERO_ONE  = 3'd2;
  localparam logic [2:0] DEC_ONE       = 3'd4;
  localparam logic [2:0] DEC_ZERO_DROP = 3'd5;
  localparam logic [2:0] DEC_ZERO_ONE2 = 3'd7;

  typedef logic [FrameWidth-1:0] frame_t;

  typedef struct packed {
    logic [TimeWidth-1:0] short_min;
    logic [TimeWidth-1:0] short_max;
    logic [TimeWidth-1:0] long_min;
    logic [TimeWidth-1:0] long_max;
  } cfg_t;

  typedef struct packed {
    logic [OutWidth-1:0] frame_bits;
    logic [1:0]          status;
    logic                answer_valid;
    logic [7:0]          answer;
  } result_t;

  function automatic logic [1:0] class_time(input logic [TimeWidth-1:0] t, input cfg_t cfg);
    logic [1:0] cls;
    if ((t > cfg.long_min) && (t < cfg.long_max)) begin
      cls = CLS_LONG;
    end else if ((t > cfg.short_min) && (t < cfg.short_max)) begin
      cls = CLS_SHORT;
    end else begin
      cls = CLS_BAD;
    end
    return cls;
  endfunction

  function automatic logic [OutWidth-1:0] frame_low(input frame_t f);
    logic [31:0] wide;
    wide = 32'(f);
    return wide[OutWidth-1:0];
  endfunction

endpackage

// ===== hdl/mbfd_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbfd_core
// next-state and result logic for one edge or frame-end transfer
// ----------------------------------------------------------------------------
module mbfd_core (
  input  logic [1:0]                    op_i,
  input  logic [mbfd_pkg::TimeWidth-1:0] duration_i,
  input  mbfd_pkg::cfg_t                cfg_i,
  input  mbfd_pkg::frame_t              frame_i,
  input  logic                          half_i,
  input  logic [mbfd_pkg::TimeWidth-1:0] high_i,
  output mbfd_pkg::frame_t              frame_o,
  output logic                          half_o,
  output logic [mbfd_pkg::TimeWidth-1:0] high_o,
  output mbfd_pkg::result_t             result_o
);
  import mbfd_pkg::*;

  logic [1:0] high_cls;
  logic [1:0] low_cls;
  logic [2:0] dec_idx;
  logic [1:0] status;
  logic       ans_valid;
  logic [7:0] ans;

  assign high_cls = class_time(high_i, cfg_i);
  assign low_cls  = class_time(duration_i, cfg_i);
  assign dec_idx  = {half_i, low_cls == CLS_LONG, high_cls == CLS_LONG};

  always_comb begin
    frame_o   = frame_i;
    half_o    = half_i;
    high_o    = high_i;
    status    = ST_OK;
    ans_valid = 1'b0;
    ans       = 8'd0;
    case (op_i)
      OP_RISE: begin
        if (frame_i == '0) begin
          frame_o = {frame_i[FrameWidth-2:0], 1'b1};
          half_o  = 1'b1;
        end else if (high_cls == CLS_BAD) begin
          frame_o = '0;
          status  = ST_HIGH_BAD;
        end else if (low_cls == CLS_BAD) begin
          frame_o = '0;
          status  = ST_LOW_BAD;
        end else begin
          case (dec_idx)
            DEC_ZERO: begin
              frame_o = {frame_i[FrameWidth-2:0], 1'b0};
            end
            DEC_ZERO_ONE, DEC_ZERO_ONE2: begin
              frame_o = {frame_i[FrameWidth-3:0], 2'b01};
              half_o  = 1'b1;
            end
            DEC_ONE: begin
              frame_o = {frame_i[FrameWidth-2:0], 1'b1};
            end
            DEC_ZERO_DROP: begin
              frame_o = {frame_i[FrameWidth-2:0], 1'b0};
              half_o  = 1'b0;
            end
            default: begin
              frame_o = '0;
              status  = ST_ILLEGAL;
            end
          endcase
        end
      end
      OP_FALL: begin
        high_o = duration_i;
      end
      OP_END: begin
        if (frame_i[AnswerBit]) begin
          ans_valid = 1'b1;
          ans       = frame_i[7:0];
        end
        frame_o = '0;
      end
      default: begin
        frame_o = frame_i;
      end
    endcase
  end

  assign result_o.frame_bits   = frame_low(frame_o);
  assign result_o.status       = status;
  assign result_o.answer_valid = ans_valid;
  assign result_o.answer       = ans;

endmodule

// ===== hdl/manchester_backward_frame_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// manchester_backward_frame_decoder
// decodes a manchester answer frame of a lighting bus from edge timings
// ----------------------------------------------------------------------------
// Input channel: one transfer per edge or frame end (op, duration). A falling
// edge stores the high time, a rising edge classes high and low times and
// shifts bits into the frame, a frame end reports the answer byte.
// Output channel: exactly one result per input transfer (frame_bits, status,
// answer_valid, answer), in input order.
// Result: each result is registered, in the skid register if the output stalls.
// Throughput: one item per cycle while in_stall_o is low; the frame state is
// updated in the cycle of the transfer, so the next item sees it at once.
// Stall: an output register plus a skid register. While the output is
// stalled one more item is still taken into the skid register; after that
// in_stall_o rises until the output drains.
// Configuration: cfg_we_i writes the register at cfg_index_i (short_min,
// short_max, long_min, long_max); write only while the block is idle.
// Reset: windows return to 333/500/667/1000, frame, half bit and stored
// high time clear, both output stages empty.
// ----------------------------------------------------------------------------
module manchester_backward_frame_decoder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_index_i,
  input  logic [mbfd_pkg::TimeWidth-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     op_i,
  input  logic [mbfd_pkg::TimeWidth-1:0] duration_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [mbfd_pkg::OutWidth-1:0]  frame_bits_o,
  output logic [1:0]                     status_o,
  output logic                           answer_valid_o,
  output logic [7:0]                     answer_o
);
  import mbfd_pkg::*;

  cfg_t                 cfg_q;
  frame_t               frame_q, frame_d;
  logic                 half_q, half_d;
  logic [TimeWidth-1:0] high_q, high_d;
  result_t              res_d;
  result_t              out_q;
  result_t              skid_q;
  logic                 out_valid_q;
  logic                 skid_valid_q;
  logic                 in_xfer;
  logic                 out_free;

  assign in_stall_o = skid_valid_q;
  assign in_xfer    = in_valid_i && !skid_valid_q;
  assign out_free   = !out_valid_q || !out_stall_i;

  mbfd_core u_core (
    .op_i       (op_i),
    .duration_i (duration_i),
    .cfg_i      (cfg_q),
    .frame_i    (frame_q),
    .half_i     (half_q),
    .high_i     (high_q),
    .frame_o    (frame_d),
    .half_o     (half_d),
    .high_o     (high_d),
    .result_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_min <= SHORT_MIN_RST;
      cfg_q.short_max <= SHORT_MAX_RST;
      cfg_q.long_min  <= LONG_MIN_RST;
      cfg_q.long_max  <= LONG_MAX_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_SHORT_MIN: cfg_q.short_min <= cfg_data_i;
        REG_SHORT_MAX: cfg_q.short_max <= cfg_data_i;
        REG_LONG_MIN:  cfg_q.long_min  <= cfg_data_i;
        REG_LONG_MAX:  cfg_q.long_max  <= cfg_data_i;
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= '0;
      half_q  <= 1'b0;
      high_q  <= '0;
    end else if (in_xfer) begin
      frame_q <= frame_d;
      half_q  <= half_d;
      high_q  <= high_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_xfer;
      end
    end else if (in_xfer) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_xfer) begin
        out_q <= res_d;
      end
    end else if (in_xfer) begin
      skid_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign frame_bits_o   = out_q.frame_bits;
  assign status_o       = out_q.status;
  assign answer_valid_o = out_q.answer_valid;
  assign answer_o       = out_q.answer;

endmodule

// ===== hdl/mbfd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbfd_checker
// port-level checks of the manchester backward frame decoder
// ----------------------------------------------------------------------------
module mbfd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [mbfd_pkg::OutWidth-1:0] frame_bits_o,
  input logic [1:0]                    status_o,
  input logic                          answer_valid_o
);
  import mbfd_pkg::*;

  // input only held back while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // an answer comes with a cleared frame and good status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && answer_valid_o) |-> (frame_bits_o == '0 && status_o == ST_OK))
    else $error("answer with nonzero frame or bad status");

  // any error clears the frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> (frame_bits_o == '0))
    else $error("error result with nonzero frame");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(frame_bits_o)
      && $stable(status_o)))
    else $error("stalled result changed");

endmodule

bind manchester_backward_frame_decoder mbfd_checker u_mbfd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .frame_bits_o   (frame_bits_o),
  .status_o       (status_o),
  .answer_valid_o (answer_valid_o)
);

// ===== tb/sv/tb_manchester_backward_frame_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_manchester_backward_frame_decoder
// self-checking bench for the manchester backward frame decoder
// ----------------------------------------------------------------------------
// Edge timings are driven into the decoder as directed cases, well-formed
// answer frames with random content, broken frames and noise. A frame
// decoder in the bench predicts every result, and the results
// are checked in order against it. Both sides idle and stall at random, the
// receiver holds off long enough to fill the block, and the timing windows
// are moved through several settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb_manchester_backward_frame_decoder;
  import mbfd_pkg::*;

  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam int         CycleLimit = 100000;
  localparam int         ReportMax  = 10;

  typedef enum logic [1:0] {SPAN_SHORT, SPAN_LONG, SPAN_BAD} span_e;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [1:0]           cfg_index_i = REG_SHORT_MIN;
  logic [TimeWidth-1:0] cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic [1:0]           op_i        = OP_RISE;
  logic [TimeWidth-1:0] duration_i  = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [OutWidth-1:0]  frame_bits_o;
  logic [1:0]           status_o;
  logic                 answer_valid_o;
  logic [7:0]           answer_o;

  manchester_backward_frame_decoder u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .duration_i     (duration_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .frame_bits_o   (frame_bits_o),
    .status_o       (status_o),
    .answer_valid_o (answer_valid_o),
    .answer_o       (answer_o)
  );

  // decoder state mirrored by the bench
  cfg_t                 win;
  frame_t               line_frame;
  logic                 line_half;
  logic [TimeWidth-1:0] held_high;

  result_t awaited_results[$];

  int  cycle_count     = 0;
  int  items_sent      = 0;
  int  results_checked = 0;
  int  answers_seen    = 0;
  int  faults_seen     = 0;
  int  mismatches      = 0;
  int  hold_left       = 0;
  bit  no_idle         = 1'b0;

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             awaited_results.size());
    $display("Some tests failed");
    $finish;
  end

  // receiver side: random stalls, or a counted hold-off
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= !no_idle && ($urandom_range(0, 99) < 34);
    end
  end

  function automatic span_e span_of(input logic [TimeWidth-1:0] t);
    if (t > win.long_min && t < win.long_max) return SPAN_LONG;
    if (t > win.short_min && t < win.short_max) return SPAN_SHORT;
    return SPAN_BAD;
  endfunction

  function automatic void shift_in(input logic b);
    line_frame = {line_frame[FrameWidth-2:0], b};
  endfunction

  function automatic result_t decode_item(input logic [1:0] op,
                                          input logic [TimeWidth-1:0] dur);
    result_t    r;
    span_e      hs;
    span_e      ls;
    logic [2:0] idx;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_RISE: begin
        if (line_frame == '0) begin
          line_half = 1'b1;
          shift_in(1'b1);
        end else begin
          hs = span_of(held_high);
          ls = span_of(dur);
          if (hs == SPAN_BAD) begin
            line_frame = '0;
            r.status = ST_HIGH_BAD;
          end else if (ls == SPAN_BAD) begin
            line_frame = '0;
            r.status = ST_LOW_BAD;
          end else begin
            idx = {line_half, ls == SPAN_LONG, hs == SPAN_LONG};
            case (idx)
              DEC_ZERO: shift_in(1'b0);
              DEC_ZERO_ONE, DEC_ZERO_ONE2: begin
                shift_in(1'b0);
                shift_in(1'b1);
                line_half = 1'b1;
              end
              DEC_ONE: shift_in(1'b1);
              DEC_ZERO_DROP: begin
                shift_in(1'b0);
                line_half = 1'b0;
              end
              default: begin
                line_frame = '0;
                r.status = ST_ILLEGAL;
              end
            endcase
          end
        end
      end
      OP_FALL: held_high = dur;
      OP_END: begin
        if (line_frame[AnswerBit]) begin
          r.answer_valid = 1'b1;
          r.answer = line_frame[7:0];
        end
        line_frame = '0;
      end
      default: ;
    endcase
    r.frame_bits = line_frame;
    return r;
  endfunction

  // result checker
  always @(posedge clk_i) begin : result_check
    result_t want;
    result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{frame_bits: frame_bits_o, status: status_o,
              answer_valid: answer_valid_o, answer: answer_o};
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportMax)
          $display("unexpected result: frame %h status %0d answer %0b/%h",
                   got.frame_bits, got.status, got.answer_valid, got.answer);
      end else begin
        want = awaited_results.pop_front();
        results_checked++;
        if (got.answer_valid) answers_seen++;
        if (got.status != ST_OK) faults_seen++;
        if (got.frame_bits !== want.frame_bits || got.status !== want.status ||
            got.answer_valid !== want.answer_valid || got.answer !== want.answer) begin
          mismatches++;
          if (mismatches <= ReportMax)
            $display("mismatch at result %0d: exp frame %h status %0d answer %0b/%h,%s",
                     results_checked, want.frame_bits, want.status, want.answer_valid,
                     want.answer, $sformatf(" got frame %h status %0d answer %0b/%h",
                     got.frame_bits, got.status, got.answer_valid, got.answer));
        end
      end
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [TimeWidth-1:0] dur);
    while (!no_idle && $urandom_range(0, 99) < 34) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    duration_i <= dur;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    awaited_results.push_back(decode_item(op, dur));
    if (op != OP_UNUSED) items_sent++;
  endtask

  task automatic wait_results_done();
    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_windows(input cfg_t w);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_SHORT_MIN;
    cfg_data_i  <= w.short_min;
    @(posedge clk_i);
    cfg_index_i <= REG_SHORT_MAX;
    cfg_data_i  <= w.short_max;
    @(posedge clk_i);
    cfg_index_i <= REG_LONG_MIN;
    cfg_data_i  <= w.long_min;
    @(posedge clk_i);
    cfg_index_i <= REG_LONG_MAX;
    cfg_data_i  <= w.long_max;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    win = w;
  endtask

  function automatic logic [TimeWidth-1:0] pick_time(input bit want_long);
    int lo;
    int hi;
    lo = want_long ? int'(win.long_min) : int'(win.short_min);
    hi = want_long ? int'(win.long_max) : int'(win.short_max);
    if (hi > lo + 1) return TimeWidth'($urandom_range(lo + 1, hi - 1));
    return TimeWidth'($urandom_range(0, 65535));
  endfunction

  function automatic logic [TimeWidth-1:0] edge_time();
    case ($urandom_range(0, 9))
      0: return win.short_min;
      1: return win.short_max;
      2: return win.long_min;
      3: return win.long_max;
      4: return win.short_min + 1'b1;
      5: return win.long_max - 1'b1;
      6: return '0;
      7: return '1;
      default: return TimeWidth'($urandom_range(0, 65535));
    endcase
  endfunction

  // one answer frame of target_bits bits, optionally broken at a random pair
  task automatic send_frame(input int target_bits, input bit spoil);
    int   bits;
    int   pair;
    int   spoil_at;
    int   left;
    bit   half;
    bit   hl;
    bit   ll;
    logic [TimeWidth-1:0] ht;
    logic [TimeWidth-1:0] lt;
    send_item(OP_FALL, TimeWidth'($urandom_range(0, 65535)));
    send_item(OP_RISE, pick_time(1'b0));
    bits     = 1;
    half     = 1'b1;
    pair     = 0;
    spoil_at = spoil ? $urandom_range(1, target_bits) : 0;
    while (bits < target_bits) begin
      pair++;
      left = target_bits - bits;
      if (pair == spoil_at) begin
        case ($urandom_range(0, 2))
          0: begin
            ht = edge_time();
            lt = pick_time(1'b0);
          end
          1: begin
            ht = pick_time(1'b0);
            lt = edge_time();
          end
          default: begin
            // illegal half-bit sequence
            ht = pick_time(!half);
            lt = half ? pick_time(1'b1) : pick_time($urandom_range(0, 1));
          end
        endcase
        send_item(OP_FALL, ht);
        send_item(OP_RISE, lt);
        break;
      end
      if (half) begin
        case ($urandom_range(0, (left >= 2) ? 2 : 1))
          0: begin
            hl = 1'b0;
            ll = 1'b0;
            bits += 1;
          end
          1: begin
            hl = 1'b1;
            ll = 1'b0;
            bits += 1;
            half = 1'b0;
          end
          default: begin
            hl = 1'b1;
            ll = 1'b1;
            bits += 2;
          end
        endcase
      end else if (left >= 2 && $urandom_range(0, 1)) begin
        hl = 1'b0;
        ll = 1'b1;
        bits += 2;
        half = 1'b1;
      end else begin
        hl = 1'b0;
        ll = 1'b0;
        bits += 1;
      end
      send_item(OP_FALL, pick_time(hl));
      send_item(OP_RISE, pick_time(ll));
    end
    send_item(OP_END, TimeWidth'($urandom_range(0, 65535)));
  endtask

  task automatic send_noise();
    logic [1:0] op;
    op = 2'($urandom_range(0, 3));
    send_item(op, $urandom_range(0, 1) ? TimeWidth'($urandom_range(0, 65535)) : edge_time());
  endtask

  task automatic run_random(input int count);
    int goal;
    goal = items_sent + count;
    while (items_sent < goal) begin
      if ($urandom_range(0, 99) < 75)
        send_frame(($urandom_range(0, 3) == 0) ? $urandom_range(2, 20) : 9,
                   $urandom_range(0, 99) < 15);
      else
        repeat ($urandom_range(1, 4)) send_noise();
    end
  endtask

  task automatic test_special_cases();
    send_item(OP_UNUSED, 16'hFFFF);  // unused op on an empty frame
    send_item(OP_END, 16'h0000);     // frame end with nothing received
    send_item(OP_RISE, 16'hFFFF);    // start bit, no timing check
    send_item(OP_FALL, 16'd333);     // high time on its exclusive bound
    send_item(OP_RISE, 16'd400);
    send_item(OP_RISE, 16'd0);
    send_item(OP_FALL, 16'd499);
    send_item(OP_RISE, 16'd500);     // low time on its exclusive bound
    send_item(OP_RISE, 16'd0);
    send_item(OP_FALL, 16'd334);
    send_item(OP_RISE, 16'd499);
    send_item(OP_FALL, 16'd999);
    send_item(OP_RISE, 16'd334);
    send_item(OP_FALL, 16'd400);
    send_item(OP_RISE, 16'd400);
    send_item(OP_FALL, 16'd400);
    send_item(OP_RISE, 16'd999);
    send_item(OP_UNUSED, 16'h0000);  // unused op shows a busy frame
    send_item(OP_FALL, 16'd668);
    send_item(OP_RISE, 16'd668);
    send_item(OP_FALL, 16'd400);
    send_item(OP_RISE, 16'd400);
    send_item(OP_END, 16'hFFFF);     // nine bits, answer expected
    send_item(OP_RISE, 16'd0);
    send_item(OP_FALL, 16'd400);
    send_item(OP_RISE, 16'd700);     // short high then long low on a set half bit
    send_item(OP_RISE, 16'd0);
    send_item(OP_FALL, 16'd700);
    send_item(OP_RISE, 16'd400);
    send_item(OP_FALL, 16'd700);
    send_item(OP_RISE, 16'd700);     // long high on a cleared half bit
  endtask

  // start bit pushed out by zeros, frame turns empty and restarts
  task automatic test_overflow();
    send_item(OP_END, 16'd0);
    send_item(OP_RISE, 16'd400);
    send_item(OP_FALL, 16'd800);
    send_item(OP_RISE, 16'd400);
    repeat (FrameWidth - 1) begin
      send_item(OP_FALL, 16'd400);
      send_item(OP_RISE, 16'd400);
    end
    send_item(OP_RISE, 16'd400);
    send_item(OP_END, 16'd0);
  endtask

  task automatic test_backpressure();
    no_idle   = 1'b1;
    hold_left = 150;
    repeat (4) send_frame(9, 1'b0);
    no_idle = 1'b0;
    wait_results_done();
  endtask

  task automatic test_no_idle();
    no_idle = 1'b1;
    run_random(120);
    no_idle = 1'b0;
    wait_results_done();
  endtask

  task automatic test_window_settings();
    cfg_t settings[6];
    settings[0] = '{short_min: 16'd100, short_max: 16'd300, long_min: 16'd300,
                    long_max: 16'd700};
    settings[1] = '{short_min: 16'd300, short_max: 16'd800, long_min: 16'd500,
                    long_max: 16'd1000};
    settings[2] = '{short_min: 16'd0, short_max: 16'd0, long_min: 16'd0,
                    long_max: 16'd0};
    settings[3] = '{short_min: 16'd0, short_max: 16'hFFFF, long_min: 16'd0,
                    long_max: 16'hFFFF};
    settings[4] = '{short_min: 16'hFFFF, short_max: 16'hFFFF, long_min: 16'hFFFF,
                    long_max: 16'hFFFF};
    settings[5] = '{short_min: SHORT_MIN_RST, short_max: SHORT_MAX_RST,
                    long_min: LONG_MIN_RST, long_max: LONG_MAX_RST};
    foreach (settings[i]) begin
      wait_results_done();
      write_windows(settings[i]);
      run_random(70);
    end
    wait_results_done();
  endtask

  initial begin
    int guard;
    win = '{short_min: SHORT_MIN_RST, short_max: SHORT_MAX_RST,
            long_min: LONG_MIN_RST, long_max: LONG_MAX_RST};
    line_frame = '0;
    line_half  = 1'b0;
    held_high  = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_special_cases();
    test_overflow();
    run_random(150);
    wait_results_done();
    test_backpressure();
    test_no_idle();
    test_window_settings();

    in_valid_i <= 1'b0;
    guard = 0;
    while (awaited_results.size() != 0 && guard < 5000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (4) @(posedge clk_i);
    if (awaited_results.size() != 0) begin
      mismatches++;
      $display("%0d results never arrived", awaited_results.size());
    end

    $display("sent %0d edge and frame-end transfers over 7 window settings", items_sent);
    $display("checked %0d results: %0d answers, %0d timing or pattern faults, %0d mismatches",
             results_checked, answers_seen, faults_seen, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
